// ===== rtl/qrm_pkg.sv =====
// Shared types and constants for the quaternion to rotation matrix core.
`timescale 1ns / 1ps
`default_nettype none
package qrm_pkg;

  // Component width, fixed by the Q2.14 payload format
  localparam int DATA_W = 16;
  // Signed product of two components
  localparam int PROD_W = 2 * DATA_W;
  // Squared norm, up to 4 * 2^(2*DATA_W-2)
  localparam int NORM_W = 2 * DATA_W + 1;
  // Signed numerator of one matrix entry
  localparam int NUM_W  = NORM_W + 1;
  // Matrix entries handled in parallel
  localparam int LANES  = 9;

  // Lane assignment of the matrix entries
  localparam int L_M00 = 0;
  localparam int L_M10 = 1;
  localparam int L_M20 = 2;
  localparam int L_M01 = 3;
  localparam int L_M11 = 4;
  localparam int L_M21 = 5;
  localparam int L_M02 = 6;
  localparam int L_M12 = 7;
  localparam int L_M22 = 8;

  typedef logic signed [DATA_W-1:0] coef_t;
  typedef logic [NORM_W-1:0]        norm_t;

  // Input transaction: one quaternion
  typedef struct packed {
    coef_t qx;
    coef_t qy;
    coef_t qz;
    coef_t qw;
  } quat_t;

  // Output transaction: nine entries plus zero-norm flag
  typedef struct packed {
    coef_t m00;
    coef_t m10;
    coef_t m20;
    coef_t m01;
    coef_t m11;
    coef_t m21;
    coef_t m02;
    coef_t m12;
    coef_t m22;
    logic  zero_norm;
  } matrix_t;

  // Sideband that travels with the divider lanes
  typedef struct packed {
    logic             zero_norm;
    logic [LANES-1:0] neg;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/qrm_products.sv =====
// Front end: component products, norm and entry numerators, sign/magnitude split.
`timescale 1ns / 1ps
`default_nettype none
module qrm_products
  import qrm_pkg::*;
(
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  wire                          sample_valid,
  input  quat_t                        sample,
  output logic                         out_valid,
  output norm_t                        den,
  output logic [LANES-1:0][NORM_W-1:0] mag,
  output side_t                        side
);

  // Stage A: ten products
  logic                     a_valid;
  logic signed [PROD_W-1:0] xx, yy, zz, ww, xy, xz, yz, wx, wy, wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx <= sample.qx * sample.qx;
      yy <= sample.qy * sample.qy;
      zz <= sample.qz * sample.qz;
      ww <= sample.qw * sample.qw;
      xy <= sample.qx * sample.qy;
      xz <= sample.qx * sample.qz;
      yz <= sample.qy * sample.qz;
      wx <= sample.qw * sample.qx;
      wy <= sample.qw * sample.qy;
      wz <= sample.qw * sample.qz;
    end
  end

  // Stage B: norm and numerators
  logic signed [NUM_W-1:0] exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;
  logic signed [NUM_W-1:0] n_s;
  logic signed [NUM_W-1:0] num_nx [LANES];

  always_comb begin
    exx = NUM_W'(xx);
    eyy = NUM_W'(yy);
    ezz = NUM_W'(zz);
    eww = NUM_W'(ww);
    exy = NUM_W'(xy);
    exz = NUM_W'(xz);
    eyz = NUM_W'(yz);
    ewx = NUM_W'(wx);
    ewy = NUM_W'(wy);
    ewz = NUM_W'(wz);
    n_s = exx + eyy + ezz + eww;
    num_nx[L_M00] = n_s - ((eyy + ezz) <<< 1);
    num_nx[L_M10] = (exy - ewz) <<< 1;
    num_nx[L_M20] = (exz + ewy) <<< 1;
    num_nx[L_M01] = (exy + ewz) <<< 1;
    num_nx[L_M11] = n_s - ((exx + ezz) <<< 1);
    num_nx[L_M21] = (eyz - ewx) <<< 1;
    num_nx[L_M02] = (exz - ewy) <<< 1;
    num_nx[L_M12] = (eyz + ewx) <<< 1;
    num_nx[L_M22] = n_s - ((exx + eyy) <<< 1);
  end

  logic                    b_valid;
  norm_t                   b_norm;
  logic signed [NUM_W-1:0] b_num [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_norm <= n_s[NORM_W-1:0];
      b_num  <= num_nx;
    end
  end

  // Stage C: sign and magnitude; every magnitude is bounded by the norm
  logic signed [NUM_W-1:0]      neg_num [LANES];
  logic [LANES-1:0]             neg_nx;
  logic [LANES-1:0][NORM_W-1:0] mag_nx;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      neg_num[l] = -b_num[l];
      neg_nx[l]  = b_num[l][NUM_W-1];
      mag_nx[l]  = neg_nx[l] ? neg_num[l][NORM_W-1:0] : b_num[l][NORM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den            <= b_norm;
      mag            <= mag_nx;
      side.neg       <= neg_nx;
      side.zero_norm <= (b_norm == '0);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qrm_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage for all nine lanes.
`timescale 1ns / 1ps
`default_nettype none
module qrm_divider
  import qrm_pkg::*;
#(
  parameter int QUOT_W = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          en,
  input  wire                          in_valid,
  input  norm_t                        in_den,
  input  wire  [LANES-1:0][NORM_W-1:0] in_mag,
  input  side_t                        in_side,
  output logic                         out_valid,
  output side_t                        out_side,
  output logic [LANES-1:0][QUOT_W-1:0] quot
);

  // Partial remainder stays below twice the divisor
  localparam int REM_W = NORM_W + 1;

  logic                         vld   [QUOT_W];
  norm_t                        den_s [QUOT_W];
  side_t                        side_s[QUOT_W];
  logic [LANES-1:0][QUOT_W-1:0] quo_s [QUOT_W];
  logic [LANES-1:0][REM_W-1:0]  rem_s [QUOT_W-1];

  for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
    logic                         v_in;
    norm_t                        d_in;
    side_t                        sd_in;
    logic [LANES-1:0][REM_W-1:0]  r_in;
    logic [LANES-1:0][QUOT_W-1:0] q_in;
    logic [LANES-1:0]             take;
    logic [LANES-1:0][QUOT_W-1:0] q_nx;

    // Stage inputs: the front end for the first stage, else the previous stage
    if (s == 0) begin : g_first
      assign v_in  = in_valid;
      assign d_in  = in_den;
      assign sd_in = in_side;
      assign q_in  = '0;
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          r_in[l] = REM_W'(in_mag[l]);
        end
      end
    end else begin : g_rest
      assign v_in  = vld[s-1];
      assign d_in  = den_s[s-1];
      assign sd_in = side_s[s-1];
      assign q_in  = quo_s[s-1];
      assign r_in  = rem_s[s-1];
    end

    // Quotient bit: does the divisor fit into the partial remainder
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        take[l] = (r_in[l] >= REM_W'(d_in));
        q_nx[l] = {q_in[l][QUOT_W-2:0], take[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_s[s]  <= d_in;
        side_s[s] <= sd_in;
        quo_s[s]  <= q_nx;
      end
    end

    // Remainder update, not needed after the last bit
    if (s < QUOT_W - 1) begin : g_rem
      logic [LANES-1:0][REM_W-1:0] diff;
      logic [LANES-1:0][REM_W-1:0] r_nx;

      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          diff[l] = take[l] ? (r_in[l] - REM_W'(d_in)) : r_in[l];
          r_nx[l] = {diff[l][REM_W-2:0], 1'b0};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_s[s] <= r_nx;
        end
      end
    end
  end

  assign out_valid = vld[QUOT_W-1];
  assign out_side  = side_s[QUOT_W-1];
  assign quot      = quo_s[QUOT_W-1];

endmodule
`default_nettype wire

// ===== rtl/qrm_output.sv =====
// Back end: rounding, sign, saturation, zero-norm override, output register and skid.
`timescale 1ns / 1ps
`default_nettype none
module qrm_output
  import qrm_pkg::*;
#(
  parameter int QUOT_W = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  input  side_t                        in_side,
  input  wire  [LANES-1:0][QUOT_W-1:0] quot,
  input  wire                          matrix_stall,
  output logic                         matrix_valid,
  output matrix_t                      matrix,
  output logic                         en
);

  localparam int CMP_W = ((QUOT_W > DATA_W) ? QUOT_W : DATA_W) + 1;
  localparam logic [CMP_W-1:0] POS_LIM = CMP_W'((64'd1 << (DATA_W - 1)) - 64'd1);
  localparam logic [CMP_W-1:0] NEG_LIM = CMP_W'(64'd1 << (DATA_W - 1));
  localparam coef_t COEF_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam coef_t COEF_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Round half away from zero on the magnitude, then saturate with sign
  logic [CMP_W-1:0] rnd [LANES];
  coef_t            val [LANES];
  matrix_t          res;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rnd[l] = (CMP_W'(quot[l]) + CMP_W'(1)) >> 1;
      if (in_side.zero_norm) begin
        val[l] = '0;
      end else if (in_side.neg[l]) begin
        val[l] = (rnd[l] > NEG_LIM) ? COEF_MIN : coef_t'(-rnd[l][DATA_W-1:0]);
      end else begin
        val[l] = (rnd[l] > POS_LIM) ? COEF_MAX : coef_t'(rnd[l][DATA_W-1:0]);
      end
    end
    res.m00       = val[L_M00];
    res.m10       = val[L_M10];
    res.m20       = val[L_M20];
    res.m01       = val[L_M01];
    res.m11       = val[L_M11];
    res.m21       = val[L_M21];
    res.m02       = val[L_M02];
    res.m12       = val[L_M12];
    res.m22       = val[L_M22];
    res.zero_norm = in_side.zero_norm;
  end

  // Output register plus one-entry skid; pipeline freezes only when skid is full
  logic    skid_valid;
  matrix_t skid;

  assign en = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!matrix_valid || !matrix_stall) begin
      matrix_valid <= skid_valid || in_valid;
      skid_valid   <= 1'b0;
    end else if (in_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!matrix_valid || !matrix_stall) begin
      matrix <= skid_valid ? skid : res;
    end else if (!skid_valid) begin
      skid <= res;
    end
  end

  // Skid holds data only behind a held output transaction
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> matrix_valid)
    else $error("skid full while output register empty");

  // A result arriving at a stalled output is parked, not dropped
  a_park_on_stall: assert property (@(posedge clk) disable iff (rst)
    (matrix_valid && matrix_stall && !skid_valid && in_valid) |=> skid_valid)
    else $error("result lost at stalled output");

  // Skid drains as soon as the output moves
  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !matrix_stall) |=> !skid_valid)
    else $error("skid did not drain");

  // Zero-norm transactions carry zeros on the diagonal and in m10, m01 and m21
  a_zero_norm: assert property (@(posedge clk) disable iff (rst)
    (matrix_valid && matrix.zero_norm) |->
      (matrix.m00 == '0 && matrix.m11 == '0 && matrix.m22 == '0 &&
       matrix.m10 == '0 && matrix.m01 == '0 && matrix.m21 == '0))
    else $error("zero-norm transaction with nonzero entries");

endmodule
`default_nettype wire

// ===== rtl/quaternion_to_rotation_matrix_core.sv =====
// Stages from accepted sample to valid matrix:
// three front-end stages, one divider stage per quotient bit (FRAC_BITS + 2), one output register.
// Throughput: one quaternion per cycle unless stalled; nine lane dividers run side by side.
// A one-entry skid behind the output register parks a result; pipeline freezes while it is full.
// Reset (synchronous, active high) clears all valid bits; no stored state otherwise.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_rotation_matrix_core
  import qrm_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  wire     clk,
  input  wire     rst,
  input  wire     sample_valid,
  output logic    sample_stall,
  input  quat_t   sample,
  output logic    matrix_valid,
  input  wire     matrix_stall,
  output matrix_t matrix
);

  // Quotient carries one bit above 1.0 and one rounding bit
  localparam int QUOT_W = FRAC_BITS + 2;

  logic                         en;
  logic                         fe_valid;
  norm_t                        fe_den;
  logic [LANES-1:0][NORM_W-1:0] fe_mag;
  side_t                        fe_side;
  logic                         dv_valid;
  side_t                        dv_side;
  logic [LANES-1:0][QUOT_W-1:0] dv_quot;

  assign sample_stall = !en;

  // Products, norm, numerators
  qrm_products u_products (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .sample_valid (sample_valid),
    .sample       (sample),
    .out_valid    (fe_valid),
    .den          (fe_den),
    .mag          (fe_mag),
    .side         (fe_side)
  );

  // Scaled quotients
  qrm_divider #(
    .QUOT_W (QUOT_W)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fe_valid),
    .in_den    (fe_den),
    .in_mag    (fe_mag),
    .in_side   (fe_side),
    .out_valid (dv_valid),
    .out_side  (dv_side),
    .quot      (dv_quot)
  );

  // Rounding, saturation, output buffering
  qrm_output #(
    .QUOT_W (QUOT_W)
  ) u_output (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (dv_valid),
    .in_side      (dv_side),
    .quot         (dv_quot),
    .matrix_stall (matrix_stall),
    .matrix_valid (matrix_valid),
    .matrix       (matrix),
    .en           (en)
  );

endmodule
`default_nettype wire
